[design/ffpa_pkg.sv]
// Shared constants, codes and types of the first-fit page allocator.
// No dependencies; every other file of the block but ffpa_ram uses it.
`timescale 1ns / 1ps

package ffpa_pkg;

   localparam int NUM_PAGES   = 1024;
   localparam int CNT_W       = $clog2(NUM_PAGES + 1);
   localparam int WORD_BITS   = 8;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int NUM_WORDS   = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PG_W        = WA_W + BIT_W;
   localparam int CHK_W       = ((CNT_W > 11) ? CNT_W : 11) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W    = 1;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;
   localparam int TOTAL_W  = 11;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOFIT   = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_ZERO,
      OP_NOFIT,
      OP_BADFREE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [PG_W-1:0]   first;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[design/ffpa_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on ffpa_pkg for field widths.
`timescale 1ns / 1ps

interface ffpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffpa_pkg::CMD_W-1:0]    cmd;
   logic [ffpa_pkg::INDEX_W-1:0]  page_index;
   logic [ffpa_pkg::COUNT_W-1:0]  page_count;

   modport source (output valid, cmd, page_index, page_count, input ready);
   modport sink   (input valid, cmd, page_index, page_count, output ready);
endinterface

interface ffpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ffpa_pkg::STATUS_W-1:0]  status;
   logic [ffpa_pkg::START_W-1:0]   run_start;
   logic [ffpa_pkg::TOTAL_W-1:0]   free_total;

   modport source (output valid, status, run_start, free_total, input ready);
   modport sink   (input valid, status, run_start, free_total, output ready);
endinterface

[design/ffpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/ffpa_front.sv]
// Request intake: accepts transfers and classifies them into queue commands.
// Depends on ffpa_pkg and ffpa_if.
`timescale 1ns / 1ps

module ffpa_front (
   ffpa_req_if.sink                req_ch,
   input  ffpa_pkg::qstat_type     qstat,
   input  logic                    clearing,
   output logic                    push_valid,
   output ffpa_pkg::cmd_type       push_cmd
);

   logic [ffpa_pkg::CHK_W-1:0] cnt_ext;
   logic [ffpa_pkg::CHK_W-1:0] idx_ext;
   logic [ffpa_pkg::CHK_W-1:0] end_ext;

   assign req_ch.ready = !qstat.full && !clearing;
   assign push_valid   = req_ch.valid && req_ch.ready;

   assign cnt_ext = ffpa_pkg::CHK_W'(req_ch.page_count);
   assign idx_ext = ffpa_pkg::CHK_W'(req_ch.page_index);
   assign end_ext = idx_ext + cnt_ext;

   always_comb begin
      push_cmd.first = ffpa_pkg::PG_W'(idx_ext);
      push_cmd.count = ffpa_pkg::CNT_W'(cnt_ext);
      if (cnt_ext == '0) begin
         push_cmd.op = ffpa_pkg::OP_ZERO;
      end else if (req_ch.cmd == ffpa_pkg::CMD_ALLOC) begin
         if (cnt_ext > ffpa_pkg::CHK_W'(ffpa_pkg::NUM_PAGES)) begin
            push_cmd.op = ffpa_pkg::OP_NOFIT;
         end else begin
            push_cmd.op = ffpa_pkg::OP_ALLOC;
         end
      end else begin
         if (end_ext > ffpa_pkg::CHK_W'(ffpa_pkg::NUM_PAGES)) begin
            push_cmd.op = ffpa_pkg::OP_BADFREE;
         end else begin
            push_cmd.op = ffpa_pkg::OP_FREE;
         end
      end
   end

endmodule

[design/ffpa_queue.sv]
// Short command queue between intake and execution.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  ffpa_pkg::cmd_type       push_cmd,
   input  logic                    pop,
   output ffpa_pkg::cmd_type       pop_cmd,
   output ffpa_pkg::qstat_type     qstat
);

   ffpa_pkg::cmd_type              entry_ff [ffpa_pkg::QUEUE_DEPTH];
   logic [ffpa_pkg::QP_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ffpa_pkg::QP_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ffpa_pkg::QC_W-1:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd     = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == ffpa_pkg::QC_W'(ffpa_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

[design/ffpa_back.sv]
// Execution engine: bitmap RAM, word-serial scan/check/modify/walk-back sequencer,
// free-page counter and response register. Depends on ffpa_pkg, ffpa_if, ffpa_ram.
`timescale 1ns / 1ps

module ffpa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ffpa_pkg::qstat_type     qstat,
   input  ffpa_pkg::cmd_type       pop_cmd,
   output logic                    pop,
   output logic                    clearing,
   ffpa_rsp_if.source              rsp_ch
);

   localparam int PGX_W = ((ffpa_pkg::PG_W > ffpa_pkg::CNT_W) ?
                           ffpa_pkg::PG_W : ffpa_pkg::CNT_W) + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_CHK_RD, S_CHK_EV,
      S_MOD_RD, S_MOD_EV, S_BACK_RD, S_BACK_EV
   } state_type;

   state_type                        state_ff, state_in;
   logic [ffpa_pkg::WA_W-1:0]        waddr_ff, waddr_in;
   logic                             is_free_ff, is_free_in;
   logic [ffpa_pkg::PG_W-1:0]        lo_ff, lo_in;
   logic [ffpa_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ffpa_pkg::CNT_W-1:0]       len_ff, len_in;
   logic [ffpa_pkg::PG_W-1:0]        rstart_ff, rstart_in;
   logic [ffpa_pkg::PG_W-1:0]        cur_ff, cur_in;
   logic [ffpa_pkg::CNT_W-1:0]       free_pages_ff, free_pages_in;
   logic                             out_valid_ff, out_valid_in;
   ffpa_pkg::status_type             out_status_ff, out_status_in;
   logic [ffpa_pkg::PG_W-1:0]        out_start_ff, out_start_in;
   logic [ffpa_pkg::CNT_W-1:0]       out_total_ff, out_total_in;

   logic                             ram_we;
   logic [ffpa_pkg::WORD_BITS-1:0]   ram_wdata;
   logic [ffpa_pkg::WORD_BITS-1:0]   ram_rdata;

   logic [PGX_W-1:0]                 last_page;
   logic [ffpa_pkg::WA_W-1:0]        last_w;
   logic [ffpa_pkg::WA_W-1:0]        lo_w;
   logic [ffpa_pkg::WORD_BITS-1:0]   mask;
   logic                             slot_free;

   ffpa_ram #(
      .WIDTH (ffpa_pkg::WORD_BITS),
      .DEPTH (ffpa_pkg::NUM_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_ff),
      .wdata (ram_wdata),
      .raddr (waddr_ff),
      .rdata (ram_rdata)
   );

   assign last_page = PGX_W'(lo_ff) + PGX_W'(count_ff) - PGX_W'(1);
   assign last_w    = last_page[ffpa_pkg::BIT_W +: ffpa_pkg::WA_W];
   assign lo_w      = lo_ff[ffpa_pkg::BIT_W +: ffpa_pkg::WA_W];
   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign clearing  = (state_ff == S_CLEAR);

   always_comb begin
      logic [PGX_W-1:0] pg;
      for (int b = 0; b < ffpa_pkg::WORD_BITS; b++) begin
         pg = PGX_W'({waddr_ff, ffpa_pkg::BIT_W'(b)});
         mask[b] = (pg >= PGX_W'(lo_ff)) && (pg <= last_page);
      end
   end

   always_comb begin
      logic                        load;
      ffpa_pkg::status_type        ld_status;
      logic [ffpa_pkg::PG_W-1:0]   ld_start;
      logic [ffpa_pkg::CNT_W-1:0]  len_v;
      logic [ffpa_pkg::PG_W-1:0]   st_v;
      logic                        found_v;
      logic                        stop_v;
      logic [ffpa_pkg::PG_W-1:0]   c_v;
      logic [ffpa_pkg::PG_W-1:0]   page_v;
      logic [ffpa_pkg::PG_W-1:0]   prev_v;

      state_in      = state_ff;
      waddr_in      = waddr_ff;
      is_free_in    = is_free_ff;
      lo_in         = lo_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      rstart_in     = rstart_ff;
      cur_in        = cur_ff;
      free_pages_in = free_pages_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_wdata     = '0;
      load          = 1'b0;
      ld_status     = ffpa_pkg::ST_OK;
      ld_start      = '0;
      len_v         = len_ff;
      st_v          = rstart_ff;
      found_v       = 1'b0;
      stop_v        = 1'b0;
      c_v           = cur_ff;
      page_v        = '0;
      prev_v        = lo_ff - 1'b1;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (waddr_ff == ffpa_pkg::WA_W'(ffpa_pkg::NUM_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               waddr_in = waddr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!qstat.empty && slot_free) begin
               pop      = 1'b1;
               lo_in    = pop_cmd.first;
               count_in = pop_cmd.count;
               case (pop_cmd.op)
                  ffpa_pkg::OP_ALLOC: begin
                     is_free_in = 1'b0;
                     waddr_in   = '0;
                     len_in     = '0;
                     state_in   = S_SCAN_RD;
                  end
                  ffpa_pkg::OP_FREE: begin
                     is_free_in = 1'b1;
                     waddr_in   = pop_cmd.first[ffpa_pkg::BIT_W +: ffpa_pkg::WA_W];
                     state_in   = S_CHK_RD;
                  end
                  ffpa_pkg::OP_ZERO: begin
                     load      = 1'b1;
                     ld_status = ffpa_pkg::ST_ZERO;
                  end
                  ffpa_pkg::OP_NOFIT: begin
                     load      = 1'b1;
                     ld_status = ffpa_pkg::ST_NOFIT;
                  end
                  default: begin
                     load      = 1'b1;
                     ld_status = ffpa_pkg::ST_BADFREE;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            for (int b = 0; b < ffpa_pkg::WORD_BITS; b++) begin
               page_v = {waddr_ff, ffpa_pkg::BIT_W'(b)};
               if (!found_v) begin
                  if (ram_rdata[b]) begin
                     if (len_v == '0) begin
                        st_v = page_v;
                     end
                     len_v = len_v + 1'b1;
                     if (len_v == count_ff) begin
                        found_v = 1'b1;
                     end
                  end else begin
                     len_v = '0;
                  end
               end
            end
            len_in    = len_v;
            rstart_in = st_v;
            if (found_v) begin
               lo_in    = st_v;
               waddr_in = st_v[ffpa_pkg::BIT_W +: ffpa_pkg::WA_W];
               state_in = S_MOD_RD;
            end else if (waddr_ff == ffpa_pkg::WA_W'(ffpa_pkg::NUM_WORDS - 1)) begin
               load      = 1'b1;
               ld_status = ffpa_pkg::ST_NOFIT;
               state_in  = S_IDLE;
            end else begin
               waddr_in = waddr_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_CHK_RD: begin
            state_in = S_CHK_EV;
         end
         S_CHK_EV: begin
            if ((ram_rdata & mask) != '0) begin
               load      = 1'b1;
               ld_status = ffpa_pkg::ST_BADFREE;
               state_in  = S_IDLE;
            end else if (waddr_ff == last_w) begin
               waddr_in = lo_w;
               state_in = S_MOD_RD;
            end else begin
               waddr_in = waddr_ff + 1'b1;
               state_in = S_CHK_RD;
            end
         end
         S_MOD_RD: begin
            state_in = S_MOD_EV;
         end
         S_MOD_EV: begin
            ram_we    = 1'b1;
            ram_wdata = is_free_ff ? (ram_rdata | mask) : (ram_rdata & ~mask);
            if (waddr_ff != last_w) begin
               waddr_in = waddr_ff + 1'b1;
               state_in = S_MOD_RD;
            end else if (!is_free_ff) begin
               free_pages_in = free_pages_ff - count_ff;
               load          = 1'b1;
               ld_start      = lo_ff;
               state_in      = S_IDLE;
            end else begin
               free_pages_in = free_pages_ff + count_ff;
               if (lo_ff == '0) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cur_in   = lo_ff;
                  waddr_in = prev_v[ffpa_pkg::BIT_W +: ffpa_pkg::WA_W];
                  state_in = S_BACK_RD;
               end
            end
         end
         S_BACK_RD: begin
            state_in = S_BACK_EV;
         end
         S_BACK_EV: begin
            for (int b = ffpa_pkg::WORD_BITS - 1; b >= 0; b--) begin
               page_v = {waddr_ff, ffpa_pkg::BIT_W'(b)};
               if (!stop_v && (page_v < cur_ff)) begin
                  if (ram_rdata[b]) begin
                     c_v = page_v;
                  end else begin
                     stop_v = 1'b1;
                  end
               end
            end
            if (stop_v || (c_v == '0)) begin
               load     = 1'b1;
               ld_start = c_v;
               state_in = S_IDLE;
            end else begin
               cur_in   = c_v;
               waddr_in = waddr_ff - 1'b1;
               state_in = S_BACK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in  = load ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
      out_status_in = load ? ld_status : out_status_ff;
      out_start_in  = load ? ld_start : out_start_ff;
      out_total_in  = load ? free_pages_in : out_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         waddr_ff      <= '0;
         free_pages_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         waddr_ff      <= waddr_in;
         free_pages_ff <= free_pages_in;
         out_valid_ff  <= out_valid_in;
      end
      is_free_ff    <= is_free_in;
      lo_ff         <= lo_in;
      count_ff      <= count_in;
      len_ff        <= len_in;
      rstart_ff     <= rstart_in;
      cur_ff        <= cur_in;
      out_status_ff <= out_status_in;
      out_start_ff  <= out_start_in;
      out_total_ff  <= out_total_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.run_start  = ffpa_pkg::START_W'(out_start_ff);
   assign rsp_ch.free_total = ffpa_pkg::TOTAL_W'(out_total_ff);

endmodule

[design/first_fit_page_allocator_top.sv]
// Top level of the first-fit page allocator: intake, queue, execution engine.
// Depends on ffpa_pkg, ffpa_if, ffpa_front, ffpa_queue, ffpa_back.
//
//  channel  dir  transfer when        payload
//  req_ch   in   valid && ready       cmd, page_index, page_count
//  rsp_ch   out  valid && ready       status, run_start, free_total
//
// The bitmap is walked one 8-page word at a time: a RAM read state, then an evaluate state.
// Alloc: dispatch, then a scan of words up to the fit, then the words of the run are cleared.
// Free: dispatch, a check of each word of the range, a set of each, then a walk back over free pages.
// Zero-count and out-of-range commands are answered at dispatch, without a RAM access.
// After reset a clearing pass writes all NUM_WORDS (128) bitmap words; req_ch.ready is low.
// A waiting response does not block intake until the two-entry queue is full.
`timescale 1ns / 1ps

module first_fit_page_allocator_top (
   input  logic        clock,
   input  logic        reset,
   ffpa_req_if.sink    req_ch,
   ffpa_rsp_if.source  rsp_ch
);

   ffpa_pkg::qstat_type  qstat;
   ffpa_pkg::cmd_type    push_cmd;
   ffpa_pkg::cmd_type    pop_cmd;
   logic                 push_valid;
   logic                 pop;
   logic                 clearing;

   ffpa_front u_front (
      .req_ch     (req_ch),
      .qstat      (qstat),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   ffpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .qstat      (qstat)
   );

   ffpa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .clearing (clearing),
      .rsp_ch   (rsp_ch)
   );

   a_fail_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status != ffpa_pkg::ST_OK) |-> rsp_ch.run_start == '0)
      else $error("failed command carries a nonzero run_start");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_ch.ready)
      else $error("intake ready while the queue is full");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty && !clearing)
      else $error("command taken from an empty queue or during clearing");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule
